// File: rtl/core/frlc_pkg.sv
// ----------------------------------------------------------------------------
// frlc_pkg: shared types and constants of the fault restart lockout table
// action codes, sequencer states, register indexes and datapath widths
// ----------------------------------------------------------------------------
package frlc_pkg;

	// widths fixed by the word layout
	localparam int unsigned NOW_W    = 32;  // real time clock seconds
	localparam int unsigned CNT_W    = 8;   // occurrence count
	localparam int unsigned MIN_W    = 16;  // decay minutes lane
	localparam int unsigned DVS_W    = 22;  // minutes * 60 fits 22 bits
	localparam int unsigned STEP_W   = 5;   // one quotient bit a cycle, 32 steps
	localparam int unsigned CFG_IX_W = 2;
	localparam int unsigned CFG_W    = 64;
	localparam int unsigned MAX_KINDS = 8;

	localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

	// configuration register indexes
	localparam logic [CFG_IX_W-1:0] REG_LIMITS   = 2'd0;
	localparam logic [CFG_IX_W-1:0] REG_MIN_LOW  = 2'd1;
	localparam logic [CFG_IX_W-1:0] REG_MIN_HIGH = 2'd2;

	localparam logic [CFG_W-1:0] LIMITS_RESET  = 64'h0303_0303_0303_0303;
	localparam logic [CFG_W-1:0] MINUTES_RESET = 64'h001E_001E_001E_001E;

	typedef enum logic [1:0] {
		ACT_FAULT   = 2'd0,
		ACT_REFRESH = 2'd1,
		ACT_CLEAR   = 2'd2
	} action_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CHECK = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_APPLY = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

endpackage

// File: rtl/core/fault_restart_lockout_counters.sv
// ----------------------------------------------------------------------------
// fault_restart_lockout_counters: auto-restart lockout table
// per fault kind occurrence counters with time stamps, saturating increment,
// time based decay by whole periods and a lockout mask over all entries
// ----------------------------------------------------------------------------
//
// channel   dir  handshake              payload
// s_axis    in   s_axis_tvalid/tready   tuser: action, tdata: index, seconds
// m_axis    out  m_axis_tvalid/tready   tdata: lockout, count, mask
// cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// for a fault event, a clear or a refresh that needs no decay, an accepted word
// passes ST_CHECK and ST_DONE to a loaded result register; a refresh that decays
// runs ST_CHECK, the 32 steps of the restoring divider in ST_DIV, ST_APPLY, ST_DONE
// s_axis_tready is high only while the sequencer is idle, one word at a time
// the result register frees the input side: a new word is taken while a result
// waits, and the sequencer holds in its last state until the register is free
// arst_n clears counts, stamps and control state and loads the register
// defaults; cfg_ready is always high
//
module fault_restart_lockout_counters #(
	parameter int unsigned FAULT_KINDS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [1:0]  s_axis_tuser,   // [1:0] action
	input  logic [39:0] s_axis_tdata,   // [2:0] fault_index, [34:3] now_seconds, zero fill
	// master side
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [0] lockout, [8:1] fault_count,
	                                    // [16:9] lockout_mask, zero fill
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int unsigned IDX_W = (FAULT_KINDS > 1) ? $clog2(FAULT_KINDS) : 1;
	localparam int unsigned NOW_W = frlc_pkg::NOW_W;
	localparam int unsigned CNT_W = frlc_pkg::CNT_W;
	localparam int unsigned DVS_W = frlc_pkg::DVS_W;
	localparam int unsigned MIN_W = frlc_pkg::MIN_W;

	// configuration registers
	logic [63:0] limits_q;
	logic [63:0] min_low_q;
	logic [63:0] min_high_q;

	// table state
	logic [CNT_W-1:0] count_q [FAULT_KINDS];
	logic [NOW_W-1:0] stamp_q [FAULT_KINDS];

	// captured word
	frlc_pkg::action_t action_q;
	logic [2:0]        idx_q;
	logic [NOW_W-1:0]  now_q;

	frlc_pkg::state_t  state_q;

	// shared divider: quotient shifts in where the dividend shifts out
	logic [NOW_W-1:0]                  quo_q;
	logic [DVS_W-1:0]                  rem_q;
	logic [DVS_W-1:0]                  dvs_q;
	logic [frlc_pkg::STEP_W-1:0]       step_q;

	// result register
	logic             out_valid_q;
	logic             out_lock_q;
	logic [CNT_W-1:0] out_count_q;
	logic [7:0]       out_mask_q;

	// addressed entry
	logic [IDX_W-1:0] ent;
	logic             idx_ok;
	logic [CNT_W-1:0] cnt_rd;
	logic [NOW_W-1:0] stamp_rd;
	logic [CNT_W-1:0] lim_rd;
	logic [MIN_W-1:0] min_rd;
	logic [127:0]     minutes_all;
	logic [DVS_W-1:0] period_secs;
	logic             decay_go;

	logic [DVS_W:0]   shifted;
	logic [DVS_W:0]   trial;

	logic [7:0]       mask;
	logic             out_load;

	assign ent         = idx_q[IDX_W-1:0];
	assign idx_ok      = ({1'b0, idx_q} < 4'(FAULT_KINDS));
	assign cnt_rd      = count_q[ent];
	assign stamp_rd    = stamp_q[ent];
	assign minutes_all = {min_high_q, min_low_q};
	assign lim_rd      = limits_q[8*idx_q +: 8];
	assign min_rd      = minutes_all[16*idx_q +: 16];

	// minutes * 60 as (m << 6) - (m << 2)
	assign period_secs = {min_rd, 6'b0} - {4'b0, min_rd, 2'b0};

	// decay only for a live entry below its limit, with a period and a clock ahead of the stamp
	assign decay_go = idx_ok && (cnt_rd != '0) && (cnt_rd < lim_rd) &&
	                  (min_rd != '0) && (now_q > stamp_rd);

	// one restoring step
	assign shifted = {rem_q, quo_q[NOW_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	// lockout over all entries, after the step has landed
	always_comb begin
		mask = '0;
		for (int i = 0; i < FAULT_KINDS; i++) begin
			mask[i] = (limits_q[8*i +: 8] != '0) && (count_q[i] >= limits_q[8*i +: 8]);
		end
	end

	assign out_load      = (state_q == frlc_pkg::ST_DONE) && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = (state_q == frlc_pkg::ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, out_mask_q, out_count_q, out_lock_q};

	// configuration, an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q   <= frlc_pkg::LIMITS_RESET;
			min_low_q  <= frlc_pkg::MINUTES_RESET;
			min_high_q <= frlc_pkg::MINUTES_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				frlc_pkg::REG_LIMITS:   limits_q   <= cfg_data;
				frlc_pkg::REG_MIN_LOW:  min_low_q  <= cfg_data;
				frlc_pkg::REG_MIN_HIGH: min_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// captured word, payload only
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			action_q <= frlc_pkg::action_t'(s_axis_tuser);
			idx_q    <= s_axis_tdata[2:0];
			now_q    <= s_axis_tdata[34:3];
		end
	end

	// sequencer and table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frlc_pkg::ST_IDLE;
			step_q  <= '0;
			for (int i = 0; i < FAULT_KINDS; i++) begin
				count_q[i] <= '0;
				stamp_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				frlc_pkg::ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= frlc_pkg::ST_CHECK;
					end
				end
				frlc_pkg::ST_CHECK: begin
					state_q <= frlc_pkg::ST_DONE;
					unique case (action_q)
						frlc_pkg::ACT_FAULT: begin
							if (idx_ok) begin
								if (cnt_rd != frlc_pkg::CNT_MAX) begin
									count_q[ent] <= cnt_rd + 8'd1;
								end
								stamp_q[ent] <= now_q;
							end
						end
						frlc_pkg::ACT_REFRESH: begin
							if (decay_go) begin
								state_q <= frlc_pkg::ST_DIV;
								step_q  <= '1;
							end
						end
						frlc_pkg::ACT_CLEAR: begin
							for (int i = 0; i < FAULT_KINDS; i++) begin
								count_q[i] <= '0;
							end
						end
						default: ;
					endcase
				end
				frlc_pkg::ST_DIV: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q <= frlc_pkg::ST_APPLY;
					end
				end
				frlc_pkg::ST_APPLY: begin
					state_q <= frlc_pkg::ST_DONE;
					if (quo_q != '0) begin
						count_q[ent] <= (quo_q >= {24'b0, cnt_rd}) ? '0 : cnt_rd - quo_q[7:0];
						stamp_q[ent] <= now_q;
					end
				end
				frlc_pkg::ST_DONE: begin
					if (out_load) begin
						state_q <= frlc_pkg::ST_IDLE;
					end
				end
				default: state_q <= frlc_pkg::ST_IDLE;
			endcase
		end
	end

	// divider datapath: elapsed seconds in, period count out
	always_ff @(posedge clk) begin
		if (state_q == frlc_pkg::ST_CHECK) begin
			quo_q <= now_q - stamp_rd;
			rem_q <= '0;
			dvs_q <= period_secs;
		end else if (state_q == frlc_pkg::ST_DIV) begin
			if (!trial[DVS_W]) begin
				rem_q <= trial[DVS_W-1:0];
				quo_q <= {quo_q[NOW_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DVS_W-1:0];
				quo_q <= {quo_q[NOW_W-2:0], 1'b0};
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_lock_q  <= idx_ok && mask[idx_q];
			out_count_q <= idx_ok ? cnt_rd : '0;
			out_mask_q  <= mask;
		end
	end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the fault restart lockout table
// streams fault, refresh, clear and unused-code words into the table and
// checks each result word against an in-bench copy of the table
// ----------------------------------------------------------------------------
module tb;
	import frlc_pkg::*;

	// action code that the block must ignore apart from reporting the entry
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int unsigned KINDS = 8;
	localparam int unsigned SEC_PER_MIN = 60;
	// the slowest word is a decaying refresh through the divider
	localparam int unsigned SETTLE = 40;
	localparam int unsigned PRINT_CAP = 60;

	typedef struct packed {
		logic [1:0]  act;
		logic [2:0]  idx;
		logic [31:0] now;
	} word_t;

	typedef struct packed {
		logic       lockout;
		logic [7:0] count;
		logic [7:0] mask;
	} reply_t;

	// receiver behavior, picked anew at random as the run goes on
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_RANDOM,
		RX_BURSTY,
		RX_STARVED
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [1:0]  s_axis_tuser = '0;   // [1:0] action
	logic [39:0] s_axis_tdata = '0;   // [2:0] fault_index, [34:3] now_seconds, zero fill
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // [0] lockout, [8:1] fault_count,
	                                  // [16:9] lockout_mask, zero fill
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	fault_restart_lockout_counters u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// bench copy of the table: registers, counts and stamps
	// ------------------------------------------------------------------
	logic [63:0] lim_reg;
	logic [63:0] min_lo_reg;
	logic [63:0] min_hi_reg;
	logic [7:0]  occ_count [KINDS];
	logic [31:0] stamp [KINDS];

	word_t       pending_words [$];     // words waiting for the driver
	reply_t      expected_replies [$];  // predicted results, oldest first
	logic [31:0] rtc = '0;              // running clock used to build words
	int          errors = 0;
	int          issued = 0;
	int          accepted = 0;

	function automatic logic [7:0] limit_lane(int i);
		return 8'(lim_reg >> (8 * i));
	endfunction

	// lockout needs a nonzero limit; a zero lane never locks
	function automatic logic is_locked(int i);
		logic [7:0] lim;
		lim = limit_lane(i);
		return lim != 0 && occ_count[i] >= lim;
	endfunction

	// update the table copy with one accepted word and build its result
	function automatic reply_t apply_word(word_t w);
		reply_t      r;
		logic [7:0]  lim;
		logic [15:0] mins;
		logic [31:0] periods;
		int          i;
		i = int'(w.idx);
		if (w.act == ACT_CLEAR) begin
			// clear wipes every count, stamps stay
			foreach (occ_count[k])
				occ_count[k] = '0;
		end else if (w.act == ACT_FAULT) begin
			if (occ_count[i] != CNT_MAX)
				occ_count[i] = occ_count[i] + 8'd1;
			stamp[i] = w.now;
		end else if (w.act == ACT_REFRESH) begin
			lim = limit_lane(i);
			mins = (i < 4) ? 16'(min_lo_reg >> (16 * i)) : 16'(min_hi_reg >> (16 * (i - 4)));
			// only nonzero counts below a nonzero limit decay, and only
			// when the clock has moved past the stamp
			if (occ_count[i] != 0 && occ_count[i] < lim && mins != 0 && w.now > stamp[i]) begin
				periods = (w.now - stamp[i]) / (SEC_PER_MIN * mins);
				if (periods != 0) begin
					if (periods >= occ_count[i])
						occ_count[i] = '0;
					else
						occ_count[i] = occ_count[i] - 8'(periods);
					stamp[i] = w.now;
				end
			end
		end
		// the unused action code leaves the table alone
		r.mask = '0;
		for (int k = 0; k < KINDS; k++)
			r.mask[k] = is_locked(k);
		r.lockout = is_locked(i);
		r.count = occ_count[i];
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (errors < PRINT_CAP)
			$display("%0t ns: %s got %0h, expected %0h", $time, what, got, want);
		errors++;
	endtask

	// ------------------------------------------------------------------
	// driver: bursts of words with random gaps between them
	// ------------------------------------------------------------------
	int    burst_left = 0;
	int    gap_left = 0;
	logic  in_taken = 1'b0;
	word_t cur_word;

	always @(negedge clk) begin
		// the slot is free when nothing is offered or the last word went in
		if (arst_n && (!s_axis_tvalid || in_taken)) begin
			if (gap_left > 0) begin
				s_axis_tvalid <= 1'b0;
				gap_left--;
			end else if (pending_words.size() > 0) begin
				cur_word = pending_words.pop_front();
				s_axis_tuser <= cur_word.act;
				s_axis_tdata <= {5'd0, cur_word.now, cur_word.idx};
				s_axis_tvalid <= 1'b1;
				issued++;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					// new burst; about four in ten run straight on with no gap
					burst_left = $urandom_range(0, 30);
					gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 45);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver: ready pattern of its own
	// ------------------------------------------------------------------
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_cycles = 0;
	int       rx_left = 0;
	logic     rx_level = 1'b0;

	always @(negedge clk) begin
		if (rx_cycles % 256 == 0)
			rx_mode = rx_mode_t'($urandom_range(0, 3));
		rx_cycles++;
		case (rx_mode)
			RX_OPEN: begin
				m_axis_tready <= 1'b1;
			end
			RX_RANDOM: begin
				m_axis_tready <= ($urandom_range(0, 9) < 7);
			end
			RX_BURSTY: begin
				// long stalls broken by short open windows
				if (rx_left == 0) begin
					rx_level = !rx_level;
					rx_left = rx_level ? $urandom_range(1, 20) : $urandom_range(1, 60);
				end
				rx_left--;
				m_axis_tready <= rx_level;
			end
			default: begin
				m_axis_tready <= ($urandom_range(0, 3) == 0);
			end
		endcase
	end

	// ------------------------------------------------------------------
	// monitor: predict on input words, check result words
	// ------------------------------------------------------------------
	word_t  seen_word;
	reply_t oldest;

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_replies.size() == 0) begin
				report_mismatch("result word with nothing pending:", int'(m_axis_tdata), 0);
			end else begin
				oldest = expected_replies.pop_front();
				if (m_axis_tdata[0] !== oldest.lockout)
					report_mismatch("lockout", int'(m_axis_tdata[0]), int'(oldest.lockout));
				if (m_axis_tdata[8:1] !== oldest.count)
					report_mismatch("fault_count", int'(m_axis_tdata[8:1]), int'(oldest.count));
				if (m_axis_tdata[16:9] !== oldest.mask)
					report_mismatch("lockout_mask", int'(m_axis_tdata[16:9]), int'(oldest.mask));
			end
		end
		in_taken <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready) begin
			seen_word.act = s_axis_tuser;
			seen_word.idx = s_axis_tdata[2:0];
			seen_word.now = s_axis_tdata[34:3];
			expected_replies.push_back(apply_word(seen_word));
			accepted++;
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// wait until every offered word is in and every result is out
	task automatic drain();
		while (pending_words.size() != 0 || issued != accepted || expected_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] index, logic [63:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (index == REG_LIMITS)
			lim_reg = value;
		else if (index == REG_MIN_LOW)
			min_lo_reg = value;
		else if (index == REG_MIN_HIGH)
			min_hi_reg = value;
	endtask

	// table must be idle here: every caller drains first
	task automatic load_regs(logic [63:0] limits, logic [63:0] min_low, logic [63:0] min_high);
		write_reg(REG_LIMITS, limits);
		write_reg(REG_MIN_LOW, min_low);
		write_reg(REG_MIN_HIGH, min_high);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_word(logic [1:0] act, logic [2:0] idx, logic [31:0] now);
		word_t w;
		w.act = act;
		w.idx = idx;
		w.now = now;
		pending_words.push_back(w);
	endtask

	// random words; the clock mostly moves forward in steps up to step_max,
	// sometimes stands, sometimes steps back, and now and then jumps anywhere
	task automatic queue_random(int n, int fault_pct, int clear_pct, int idx_hi, int step_max);
		word_t w;
		int    r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < fault_pct)
				w.act = ACT_FAULT;
			else if (r < fault_pct + clear_pct)
				w.act = ACT_CLEAR;
			else if (r == 99)
				w.act = ACT_UNUSED;
			else
				w.act = ACT_REFRESH;
			w.idx = 3'($urandom_range(0, idx_hi));
			r = $urandom_range(0, 99);
			if (r < 80)
				rtc = rtc + $urandom_range(0, step_max);
			else if (r >= 88 && r < 95)
				rtc = rtc - $urandom_range(0, step_max);
			else if (r >= 95)
				rtc = $urandom;
			w.now = rtc;
			// hold the sender once mid-phase until the table has caught up
			if (k == n / 2)
				drain();
			pending_words.push_back(w);
		end
		drain();
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		logic [63:0] lim_v;
		logic [63:0] lo_v;
		logic [63:0] hi_v;

		lim_reg = LIMITS_RESET;
		min_lo_reg = MINUTES_RESET;
		min_hi_reg = MINUTES_RESET;
		foreach (occ_count[k]) begin
			occ_count[k] = '0;
			stamp[k] = '0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// directed: limits 0xFF, 0, 1, 5, then 3s; minutes 0xFFFF, 1, 1, 1,
		// then 0, 1, 2, 0xFFFF
		load_regs(64'h0303_0303_0501_00FF, 64'h0001_0001_0001_FFFF, 64'hFFFF_0002_0001_0000);
		queue_word(ACT_FAULT, 3'd0, 32'd0);
		queue_word(ACT_FAULT, 3'd0, 32'hFFFF_FFFF);
		queue_word(ACT_REFRESH, 3'd0, 32'd5);         // clock behind the stamp
		queue_word(ACT_FAULT, 3'd1, 32'd100);
		queue_word(ACT_FAULT, 3'd1, 32'd100);
		queue_word(ACT_REFRESH, 3'd1, 32'd100000);    // zero limit never decays
		queue_word(ACT_FAULT, 3'd2, 32'd10);          // reaches limit of one
		queue_word(ACT_REFRESH, 3'd2, 32'd100000);    // locked entry holds
		queue_word(ACT_FAULT, 3'd3, 32'd1000);
		queue_word(ACT_FAULT, 3'd3, 32'd1000);
		queue_word(ACT_FAULT, 3'd3, 32'd1000);
		queue_word(ACT_REFRESH, 3'd3, 32'd1030);      // under one period
		queue_word(ACT_REFRESH, 3'd3, 32'd1130);      // two periods, count 3 to 1
		queue_word(ACT_REFRESH, 3'd3, 32'd1730);      // decay beyond count
		queue_word(ACT_FAULT, 3'd4, 32'd0);
		queue_word(ACT_REFRESH, 3'd4, 32'd999999);    // zero minutes
		queue_word(ACT_REFRESH, 3'd5, 32'd50);        // empty entry
		queue_word(ACT_FAULT, 3'd5, 32'd200);
		queue_word(ACT_REFRESH, 3'd5, 32'd200);       // clock equal to stamp
		queue_word(ACT_UNUSED, 3'd2, 32'h7FFF_FFFF);
		queue_word(ACT_FAULT, 3'd7, 32'd12345);
		queue_word(ACT_CLEAR, 3'd6, 32'd0);
		queue_word(ACT_REFRESH, 3'd7, 32'hFFFF_FFFF);
		drain();

		// power-on values written back explicitly
		load_regs(LIMITS_RESET, MINUTES_RESET, MINUTES_RESET);
		queue_random(450, 45, 3, 7, 4000);

		// short periods and small limits, so decay and lockout both show up
		for (int k = 0; k < 8; k++)
			lim_v[8 * k +: 8] = 8'($urandom_range(0, 6));
		for (int k = 0; k < 4; k++) begin
			lo_v[16 * k +: 16] = 16'($urandom_range(0, 3));
			hi_v[16 * k +: 16] = 16'($urandom_range(0, 3));
		end
		load_regs(lim_v, lo_v, hi_v);
		queue_random(450, 45, 3, 7, 300);

		// all ones: one entry hammered until its count saturates
		load_regs('1, '1, '1);
		queue_random(350, 92, 0, 0, 2000000);

		// all zeros: no lockout, no decay
		load_regs('0, '0, '0);
		queue_random(300, 45, 3, 7, 4000);

		// fully random register contents
		load_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
		queue_random(400, 50, 3, 7, 1000000);

		drain();
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#40_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: fault_restart_lockout_counters.f
rtl/core/frlc_pkg.sv
rtl/core/fault_restart_lockout_counters.sv
sim/tb.sv
